// ----- hdl/protobuf_field_encoder_unit_defines.svh -----
// Assertion macros shared by the protobuf field encoder RTL.
// Plain text macros only; no dependencies.
`ifndef PROTOBUF_FIELD_ENCODER_UNIT_DEFINES_SVH
`define PROTOBUF_FIELD_ENCODER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define PFE_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Check that a condition implies another in the following cycle
`define PFE_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hdl/pfe_pkg.sv -----
// Package for the protobuf field encoder: field widths, microcode format,
// control and status structs, the control store and value coding functions.
package pfe_pkg;

   localparam int ModeW  = 3;
   localparam int LongW  = 29;
   localparam int ShortW = 8;
   localparam int ValueW = 64;
   localparam int ByteW  = 8;
   localparam int KeyW   = 32;
   localparam int StepW  = 3;
   localparam int CntW   = 3;

   // Value modes
   localparam logic [ModeW-1:0] MODE_RAW   = 3'd0;
   localparam logic [ModeW-1:0] MODE_ZZ8   = 3'd1;
   localparam logic [ModeW-1:0] MODE_ZZ16  = 3'd2;
   localparam logic [ModeW-1:0] MODE_ZZ32  = 3'd3;
   localparam logic [ModeW-1:0] MODE_ZZ64  = 3'd4;
   localparam logic [ModeW-1:0] MODE_FIX32 = 3'd5;
   localparam logic [ModeW-1:0] MODE_FIX64 = 3'd6;

   // Wire types
   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_FIX64  = 3'd1;
   localparam logic [2:0] WIRE_FIX32  = 3'd5;

   // Bytes of a fixed field, less one
   localparam logic [CntW-1:0] FIX32_CNT = 3'd3;
   localparam logic [CntW-1:0] FIX64_CNT = 3'd7;

   // Datapath operations
   localparam logic [1:0] OP_ACCEPT  = 2'd0;
   localparam logic [1:0] OP_VARINT  = 2'd1;
   localparam logic [1:0] OP_LOADVAL = 2'd2;
   localparam logic [1:0] OP_FIXED   = 2'd3;

   // Jump conditions
   localparam logic [1:0] COND_NOREQ  = 2'd0;
   localparam logic [1:0] COND_MORE   = 2'd1;
   localparam logic [1:0] COND_FIXED  = 2'd2;
   localparam logic [1:0] COND_CNT_NZ = 2'd3;

   // Program steps
   localparam logic [StepW-1:0] STEP_IDLE    = 3'd0;
   localparam logic [StepW-1:0] STEP_KEY     = 3'd1;
   localparam logic [StepW-1:0] STEP_LOADVAL = 3'd2;
   localparam logic [StepW-1:0] STEP_VARINT  = 3'd3;
   localparam logic [StepW-1:0] STEP_FIXED   = 3'd4;

   typedef struct packed {
      logic [1:0]       op;
      logic [1:0]       cond;
      logic [StepW-1:0] jump;
      logic [StepW-1:0] next;
      logic             fin;
   } ucode_type;

   typedef struct packed {
      logic [1:0] op;
      logic       en;
      logic       last;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic more;
      logic fixed;
      logic cnt_nz;
   } stat_type;

   // Control store: one word per step
   function automatic ucode_type pfe_ucode(input logic [StepW-1:0] step);
      ucode_type w;
      case (step)
         STEP_IDLE:    w = '{OP_ACCEPT,  COND_NOREQ,  STEP_IDLE,    STEP_KEY,     1'b0};
         STEP_KEY:     w = '{OP_VARINT,  COND_MORE,   STEP_KEY,     STEP_LOADVAL, 1'b0};
         STEP_LOADVAL: w = '{OP_LOADVAL, COND_FIXED,  STEP_FIXED,   STEP_VARINT,  1'b0};
         STEP_VARINT:  w = '{OP_VARINT,  COND_MORE,   STEP_VARINT,  STEP_IDLE,    1'b1};
         STEP_FIXED:   w = '{OP_FIXED,   COND_CNT_NZ, STEP_FIXED,   STEP_IDLE,    1'b1};
         default:      w = '{OP_LOADVAL, COND_FIXED,  STEP_IDLE,    STEP_IDLE,    1'b0};
      endcase
      return w;
   endfunction

   // Zigzag of the low bits chosen by mode; other modes pass the word through
   function automatic logic [ValueW-1:0] pfe_code_value(input logic [ModeW-1:0] mode,
                                                        input logic [ValueW-1:0] v);
      logic [ValueW-1:0] r;
      case (mode)
         MODE_ZZ8:  r = {56'd0, {v[6:0], 1'b0} ^ {8{v[7]}}};
         MODE_ZZ16: r = {48'd0, {v[14:0], 1'b0} ^ {16{v[15]}}};
         MODE_ZZ32: r = {32'd0, {v[30:0], 1'b0} ^ {32{v[31]}}};
         MODE_ZZ64: r = {v[62:0], 1'b0} ^ {64{v[63]}};
         default:   r = v;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/pfe_if.sv -----
// Channel interfaces of the protobuf field encoder: request and response.
// Depends on pfe_pkg for field widths.
interface pfe_req_if import pfe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ModeW-1:0]  mode;
   logic [LongW-1:0]  long_id;
   logic [ShortW-1:0] short_id;
   logic [ValueW-1:0] value;

   modport source (output valid, mode, long_id, short_id, value, input ready);
   modport sink   (input valid, mode, long_id, short_id, value, output ready);
endinterface

interface pfe_rsp_if import pfe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] out_byte;
   logic             last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

// ----- hdl/pfe_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on pfe_pkg for the microcode format and control structs.
module pfe_sequencer import pfe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   logic [StepW-1:0] step_ff, step_in;
   ucode_type        word;
   logic             take;
   logic             advance;

   // Fetch the control word and evaluate its jump condition
   always_comb begin
      word = pfe_ucode(step_ff);
      case (word.cond)
         COND_NOREQ:  take = !stat.req_valid;
         COND_MORE:   take = stat.more;
         COND_FIXED:  take = stat.fixed;
         COND_CNT_NZ: take = stat.cnt_nz;
         default:     take = 1'b0;
      endcase
   end

   // Hold emitting steps while the output register is still occupied
   always_comb begin
      advance = ((word.op != OP_VARINT) && (word.op != OP_FIXED)) || stat.out_free;
      step_in = step_ff;
      if (advance) begin
         step_in = take ? word.jump : word.next;
      end
      ctrl.op   = word.op;
      ctrl.en   = advance;
      ctrl.last = word.fin && !take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ----- hdl/pfe_datapath.sv -----
// Datapath: field capture, key and value shift register, byte counter and
// output register. Depends on pfe_pkg and the channel interfaces.
module pfe_datapath import pfe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  ctrl_type  ctrl,
   output stat_type  stat,
   pfe_req_if.sink   req_bus,
   pfe_rsp_if.source rsp_bus
);

   logic [ValueW-1:0] sh_ff, sh_in;
   logic [ValueW-1:0] val_ff, val_in;
   logic [ModeW-1:0]  mode_ff, mode_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [ByteW-1:0]  obyte_ff, obyte_in;
   logic              olast_ff, olast_in;
   logic              ovalid_ff, ovalid_in;

   logic [LongW-1:0]  id;
   logic [2:0]        wire_type;
   logic              more;
   logic              fixed;

   // Field number and wire type of the incoming word
   always_comb begin
      id = (req_bus.short_id != '0) ? {{(LongW-ShortW){1'b0}}, req_bus.short_id}
                                    : req_bus.long_id;
      case (req_bus.mode)
         MODE_FIX32: wire_type = WIRE_FIX32;
         MODE_FIX64: wire_type = WIRE_FIX64;
         default:    wire_type = WIRE_VARINT;
      endcase
   end

   assign more  = (sh_ff[ValueW-1:7] != '0);
   assign fixed = (mode_ff == MODE_FIX32) || (mode_ff == MODE_FIX64);

   assign stat.req_valid = req_bus.valid;
   assign stat.out_free  = !ovalid_ff || rsp_bus.ready;
   assign stat.more      = more;
   assign stat.fixed     = fixed;
   assign stat.cnt_nz    = (cnt_ff != '0);

   assign req_bus.ready = (ctrl.op == OP_ACCEPT);

   // Carry out the operation of the current step
   always_comb begin
      sh_in     = sh_ff;
      val_in    = val_ff;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      ovalid_in = ovalid_ff && !rsp_bus.ready;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_ACCEPT: begin
               if (req_bus.valid) begin
                  sh_in   = {{(ValueW-KeyW){1'b0}}, id, wire_type};
                  val_in  = req_bus.value;
                  mode_in = req_bus.mode;
               end
            end
            OP_VARINT: begin
               obyte_in  = {more, sh_ff[6:0]};
               olast_in  = ctrl.last;
               ovalid_in = 1'b1;
               sh_in     = sh_ff >> 7;
            end
            OP_LOADVAL: begin
               sh_in  = pfe_code_value(mode_ff, val_ff);
               cnt_in = (mode_ff == MODE_FIX32) ? FIX32_CNT : FIX64_CNT;
            end
            OP_FIXED: begin
               obyte_in  = sh_ff[ByteW-1:0];
               olast_in  = ctrl.last;
               ovalid_in = 1'b1;
               sh_in     = sh_ff >> ByteW;
               cnt_in    = cnt_ff - 1'b1;
            end
            default: begin
               sh_in = sh_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff    <= sh_in;
      val_ff   <= val_in;
      mode_ff  <= mode_in;
      cnt_ff   <= cnt_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   assign rsp_bus.valid    = ovalid_ff;
   assign rsp_bus.out_byte = obyte_ff;
   assign rsp_bus.last     = olast_ff;

endmodule

// ----- hdl/protobuf_field_encoder_unit.sv -----
// Protobuf scalar field encoder, top level.
// req_bus takes one scalar field per word: mode, long_id, short_id, value.
// rsp_bus returns the encoded field one byte per word, key varint first,
// then the value; last marks the final byte of the field.
// The first key byte is formed at the key step, after the accept step, and is offered from the output register.
// Per field the microcode steps through one accept step, one step per key
// byte (K = 1..5 key bytes), one value load step and one step per value
// byte (V = 1..10 value bytes); an emitting step holds while output stalls.
// Only one field is held at a time; ready is high while the sequencer sits
// at its idle step, which includes the cycles in which the final byte of
// the previous field still waits in the output register.
// A stalled receiver holds the output byte and freezes the sequencer at its
// emitting step until the byte is taken.
// Reset (synchronous, active high) returns the sequencer to idle and empties
// the output register.
// Depends on pfe_pkg, the channel interfaces and the assertion macros.
`include "protobuf_field_encoder_unit_defines.svh"

module protobuf_field_encoder_unit import pfe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pfe_req_if.sink   req_bus,
   pfe_rsp_if.source rsp_bus
);

   ctrl_type ctrl;
   stat_type stat;

   // Step through the encoding program
   pfe_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // Capture, shift and emit bytes
   pfe_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .stat    (stat),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Checks on the sequencer and output register
   `PFE_ASSERT_NEXT(a_one_field, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "field taken while another is in flight")
   `PFE_ASSERT_SAME(a_no_overrun, clock, reset, ctrl.en && ((ctrl.op == OP_VARINT) || (ctrl.op == OP_FIXED)), !rsp_bus.valid || rsp_bus.ready, "output byte overwritten before taken")
   `PFE_ASSERT_NEXT(a_first_byte, clock, reset, req_bus.valid && req_bus.ready, ctrl.op == OP_VARINT, "key not emitted after field taken")

endmodule
